FILE: hdl/pmfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_pkg
// Shared types, codes and constants for the paged monochrome framebuffer.
// ----------------------------------------------------------------------------
package pmfb_pkg;

   localparam int DEF_PANEL_WIDTH      = 128;
   localparam int DEF_PANEL_HEIGHT     = 64;
   localparam int DEF_BRIGHTNESS_STEPS = 32;

   localparam logic [6:0] BUS_ADDRESS_RESET = 7'd60;
   localparam int         HEAD_LEN          = 8;   // command transfer plus data control byte
   localparam int         QUEUE_DEPTH       = 2;

   localparam logic [1:0] OP_PLOT   = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_NEXT   = 2'd2;
   localparam logic [1:0] OP_BRIGHT = 2'd3;

   localparam logic [7:0] CTRL_CMD     = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;
   localparam logic [7:0] CMD_COL_ADDR = 8'h21;
   localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
   localparam logic [7:0] CMD_CONTRAST = 8'h81;
   localparam logic [7:0] BRIGHT_MAX   = 8'hFF;

   typedef enum logic [1:0] {
      KIND_PLOT,
      KIND_CLEAR,
      KIND_NEXT,
      KIND_BRIGHT
   } kind_type;

   // one queued request; the store address travels beside it
   typedef struct packed {
      kind_type   kind;
      logic [2:0] bit_sel;
      logic       lit;
      logic [7:0] value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // fixed bytes at the head of the refresh stream
   function automatic logic [7:0] stream_head(input logic [2:0] pos,
                                              input logic [7:0] last_col,
                                              input logic [2:0] last_page);
      logic [7:0] b;
      case (pos)
         3'd0:    b = CTRL_CMD;
         3'd1:    b = CMD_COL_ADDR;
         3'd2:    b = 8'h00;
         3'd3:    b = last_col;
         3'd4:    b = CMD_PAGE_ADDR;
         3'd5:    b = 8'h00;
         3'd6:    b = {5'd0, last_page};
         default: b = CTRL_DATA;
      endcase
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/pmfb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module pmfb_queue import pmfb_pkg::*; #(
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cmd_type           push_cmd,
   input  wire logic [ADDR_W-1:0] push_addr,
   input  wire logic              pop,
   output cmd_type                head_cmd,
   output logic [ADDR_W-1:0]      head_addr,
   output queue_status_type       status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           cmd_ff  [QUEUE_DEPTH];
   logic [ADDR_W-1:0] addr_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff]  <= push_cmd;
         addr_ff[wr_ptr_ff] <= push_addr;
      end
   end

   assign head_cmd     = cmd_ff[rd_ptr_ff];
   assign head_addr    = addr_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

FILE: hdl/pmfb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_front
// Accepts requests, range-checks plots, works out store addresses and
// contrast values, and queues the work for the back part.
// ----------------------------------------------------------------------------
module pmfb_front import pmfb_pkg::*; #(
   parameter int PANEL_WIDTH      = DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT     = DEF_PANEL_HEIGHT,
   parameter int BRIGHTNESS_STEPS = DEF_BRIGHTNESS_STEPS,
   parameter int ADDR_W           = 10
) (
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic               req_lit,
   input  wire logic [7:0]         req_level,
   input  wire queue_status_type   q_status,
   input  wire back_status_type    bk_status,
   output logic                    push,
   output cmd_type                 push_cmd,
   output logic [ADDR_W-1:0]       push_addr
);

   logic accept;
   logic keep;
   logic in_range;

   assign busy   = q_status.full || bk_status.clearing;
   assign accept = start && !busy;

   assign in_range = !req_pos_x[15] && (req_pos_x < 16'(PANEL_WIDTH)) &&
                     !req_pos_y[15] && (req_pos_y < 16'(PANEL_HEIGHT));

   always_comb begin
      keep              = 1'b1;
      push_cmd.kind     = KIND_PLOT;
      push_cmd.bit_sel  = req_pos_y[2:0];
      push_cmd.lit      = req_lit;
      push_cmd.value    = BRIGHT_MAX;
      push_addr         = ADDR_W'(32'(req_pos_y[15:3]) * 32'(PANEL_WIDTH)
                                  + 32'(req_pos_x[14:0]));
      case (req_op)
         OP_PLOT: begin
            push_cmd.kind = KIND_PLOT;
            keep          = in_range;   // drop plots off the panel
         end
         OP_CLEAR: push_cmd.kind = KIND_CLEAR;
         OP_NEXT:  push_cmd.kind = KIND_NEXT;
         OP_BRIGHT: begin
            push_cmd.kind = KIND_BRIGHT;
            if (req_level < 8'(BRIGHTNESS_STEPS)) begin
               push_cmd.value = {req_level[4:0], 3'b000};
            end
         end
         default: keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

endmodule
`default_nettype wire

FILE: hdl/pmfb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmfb_back
// Owns the pixel store and the refresh position; carries out queued
// requests and drives the result strobe.
// ----------------------------------------------------------------------------
module pmfb_back import pmfb_pkg::*; #(
   parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
   parameter int ADDR_W       = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           head_cmd,
   input  wire logic [ADDR_W-1:0] head_addr,
   input  wire queue_status_type  q_status,
   output logic                   pop,
   output back_status_type        bk_status,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_first_of_transfer,
   output logic                   rsp_last_of_transfer,
   output logic                   rsp_frame_done,
   output logic                   rsp_last_in_run
);

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int STREAM_LEN  = HEAD_LEN + STORE_BYTES;
   localparam int POS_W       = $clog2(STREAM_LEN);
   localparam logic [7:0] LAST_COL  = 8'(PANEL_WIDTH - 1);
   localparam logic [2:0] LAST_PAGE = 3'(PAGE_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLOT,
      ST_NEXT,
      ST_BRI1,
      ST_BRI2,
      ST_CLEAR
   } state_type;

   logic [7:0]        mem [STORE_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        bit_mask;

   state_type         state_ff;
   cmd_type           cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] sweep_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              strobe_ff;
   logic [7:0]        byte_ff;
   logic              first_ff;
   logic              last_ff;
   logic              done_ff;
   logic              run_ff;
   logic              pos_final;

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign pos_final = (pos_ff == POS_W'(STREAM_LEN - 1));
   assign bit_mask  = 8'(1) << cmd_ff.bit_sel;

   // read address: plot reads its byte, next reads the stream position
   always_comb begin
      if (head_cmd.kind == KIND_PLOT) begin
         rd_addr = head_addr;
      end else begin
         rd_addr = ADDR_W'(pos_ff - POS_W'(HEAD_LEN));
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = cmd_ff.lit ? (rd_data_ff | bit_mask) : (rd_data_ff & ~bit_mask);
      if (state_ff == ST_PLOT) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = sweep_ff;
         wr_data = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         sweep_ff  <= '0;
         pos_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  cmd_ff  <= head_cmd;
                  addr_ff <= head_addr;
                  case (head_cmd.kind)
                     KIND_PLOT:  state_ff <= ST_PLOT;
                     KIND_CLEAR: begin
                        sweep_ff <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     KIND_NEXT:  state_ff <= ST_NEXT;
                     default: begin
                        // contrast transfer opens with a fresh start
                        strobe_ff <= 1'b1;
                        byte_ff   <= CTRL_CMD;
                        first_ff  <= 1'b1;
                        last_ff   <= 1'b0;
                        done_ff   <= 1'b0;
                        run_ff    <= 1'b0;
                        state_ff  <= ST_BRI1;
                     end
                  endcase
               end
            end
            ST_PLOT: state_ff <= ST_IDLE;
            ST_NEXT: begin
               strobe_ff <= 1'b1;
               byte_ff   <= (pos_ff < POS_W'(HEAD_LEN))
                            ? stream_head(pos_ff[2:0], LAST_COL, LAST_PAGE) : rd_data_ff;
               first_ff  <= (pos_ff == '0) || (pos_ff == POS_W'(HEAD_LEN - 1));
               last_ff   <= (pos_ff == POS_W'(HEAD_LEN - 2)) || pos_final;
               done_ff   <= pos_final;
               run_ff    <= 1'b1;
               pos_ff    <= pos_final ? '0 : pos_ff + 1'b1;
               state_ff  <= ST_IDLE;
            end
            ST_BRI1: begin
               strobe_ff <= 1'b1;
               byte_ff   <= CMD_CONTRAST;
               first_ff  <= 1'b0;
               state_ff  <= ST_BRI2;
            end
            ST_BRI2: begin
               strobe_ff <= 1'b1;
               byte_ff   <= cmd_ff.value;
               last_ff   <= 1'b1;
               run_ff    <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            ST_CLEAR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == ADDR_W'(STORE_BYTES - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign bk_status.clearing   = (state_ff == ST_CLEAR);
   assign rsp_strobe            = strobe_ff;
   assign rsp_out_byte          = byte_ff;
   assign rsp_first_of_transfer = first_ff;
   assign rsp_last_of_transfer  = last_ff;
   assign rsp_frame_done        = done_ff;
   assign rsp_last_in_run       = run_ff;

endmodule
`default_nettype wire

FILE: hdl/paged_mono_framebuffer_flush.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_mono_framebuffer_flush
// Page-organized monochrome framebuffer with refresh-stream generation.
// ----------------------------------------------------------------------------
//   channel   handshake               payload
//   request   start / busy            req_op, req_pos_x, req_pos_y, req_lit, req_level
//   response  rsp_strobe (no stall)   rsp_out_byte, rsp_bus_address, transfer flags
//   csr       csr_valid / csr_ready   csr_data (bus address)
//
// Requests enter a two-entry queue at up to one per cycle while busy is low;
// the back part carries out plot as a store read, then a write; next as a store
// read, then a strobe; brightness as three strobed bytes; clear as a sweep that
// zeroes every store byte. After reset a clearing pass holds busy high; a clear
// request holds busy high for its sweep as well. Responses are strobed for
// one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module paged_mono_framebuffer_flush import pmfb_pkg::*; #(
   parameter int PANEL_WIDTH      = DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT     = DEF_PANEL_HEIGHT,
   parameter int BRIGHTNESS_STEPS = DEF_BRIGHTNESS_STEPS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_op,
   input  wire logic signed [15:0] req_pos_x,
   input  wire logic signed [15:0] req_pos_y,
   input  wire logic               req_lit,
   input  wire logic [7:0]         req_level,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_out_byte,
   output logic [6:0]              rsp_bus_address,
   output logic                    rsp_first_of_transfer,
   output logic                    rsp_last_of_transfer,
   output logic                    rsp_frame_done,
   output logic                    rsp_last_in_run,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [6:0]         csr_data
);

   localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);

   logic [6:0]        bus_address_ff;
   logic              push;
   logic              pop;
   cmd_type           push_cmd;
   cmd_type           head_cmd;
   logic [ADDR_W-1:0] push_addr;
   logic [ADDR_W-1:0] head_addr;
   queue_status_type  q_status;
   back_status_type   bk_status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_address_ff <= BUS_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         bus_address_ff <= csr_data;
      end
   end

   assign rsp_bus_address = bus_address_ff;

   pmfb_front #(
      .PANEL_WIDTH      (PANEL_WIDTH),
      .PANEL_HEIGHT     (PANEL_HEIGHT),
      .BRIGHTNESS_STEPS (BRIGHTNESS_STEPS),
      .ADDR_W           (ADDR_W)
   ) u_front (
      .start     (start),
      .busy      (busy),
      .req_op    (req_op),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_lit   (req_lit),
      .req_level (req_level),
      .q_status  (q_status),
      .bk_status (bk_status),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_addr (push_addr)
   );

   pmfb_queue #(
      .ADDR_W (ADDR_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_addr (push_addr),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .head_addr (head_addr),
      .status    (q_status)
   );

   pmfb_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .ADDR_W       (ADDR_W)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_cmd              (head_cmd),
      .head_addr             (head_addr),
      .q_status              (q_status),
      .pop                   (pop),
      .bk_status             (bk_status),
      .rsp_strobe            (rsp_strobe),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_first_of_transfer (rsp_first_of_transfer),
      .rsp_last_of_transfer  (rsp_last_of_transfer),
      .rsp_frame_done        (rsp_frame_done),
      .rsp_last_in_run       (rsp_last_in_run)
   );

endmodule
`default_nettype wire

FILE: tb/sv/pmfb_flush_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmfb_flush_checker
// Watches requests, bus-address writes and strobed bus bytes of the paged
// framebuffer. Keeps a shadow framebuffer, refresh position and bus address,
// predicts the bytes each request causes and compares every strobed byte,
// field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module pmfb_flush_checker import pmfb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic               req_lit,
   input  logic [7:0]         req_level,
   input  logic               rsp_strobe,
   input  logic [7:0]         rsp_out_byte,
   input  logic [6:0]         rsp_bus_address,
   input  logic               rsp_first_of_transfer,
   input  logic               rsp_last_of_transfer,
   input  logic               rsp_frame_done,
   input  logic               rsp_last_in_run,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [6:0]         csr_data,
   output int                 errors,
   output int                 pending
);

   localparam int PAGES     = (DEF_PANEL_HEIGHT + 7) / 8;
   localparam int FB_BYTES  = DEF_PANEL_WIDTH * PAGES;
   localparam int CMD_BYTES = HEAD_LEN - 1;
   localparam int FRAME_LEN = HEAD_LEN + FB_BYTES;

   typedef struct {
      logic [7:0] data;
      logic [6:0] addr;
      logic       first;
      logic       last;
      logic       done;
      logic       run_end;
   } bus_byte_t;

   logic [7:0]  shadow_fb [FB_BYTES];
   logic [10:0] stream_pos;
   logic [6:0]  bus_addr;
   bus_byte_t   bytes_due [$];
   int          err_count = 0;

   function automatic bus_byte_t make_byte(input logic [7:0] data, input logic first,
                                           input logic last, input logic done,
                                           input logic run_end);
      bus_byte_t b;
      b.data    = data;
      b.addr    = bus_addr;
      b.first   = first;
      b.last    = last;
      b.done    = done;
      b.run_end = run_end;
      return b;
   endfunction

   function automatic logic [7:0] stream_byte_at(input logic [10:0] p);
      logic [7:0] b;
      case (p)
         11'd0:   b = CTRL_CMD;
         11'd1:   b = CMD_COL_ADDR;
         11'd2:   b = 8'h00;
         11'd3:   b = 8'(DEF_PANEL_WIDTH - 1);
         11'd4:   b = CMD_PAGE_ADDR;
         11'd5:   b = 8'h00;
         11'd6:   b = 8'(PAGES - 1);
         11'd7:   b = CTRL_DATA;
         default: b = shadow_fb[int'(p) - HEAD_LEN];
      endcase
      return b;
   endfunction

   task automatic apply_request(input logic [1:0] op, input logic signed [15:0] x,
                                input logic signed [15:0] y, input logic lit,
                                input logic [7:0] level);
      int         idx;
      logic [7:0] mask;
      logic [7:0] contrast;
      logic       wrap;
      case (op)
         OP_PLOT: begin
            // drop pixels off the panel, negative ones included
            if (x >= 0 && x < 16'(DEF_PANEL_WIDTH) &&
                y >= 0 && y < 16'(DEF_PANEL_HEIGHT)) begin
               idx  = (int'(y) / 8) * DEF_PANEL_WIDTH + int'(x);
               mask = 8'd1 << y[2:0];
               if (lit) begin
                  shadow_fb[idx] = shadow_fb[idx] | mask;
               end else begin
                  shadow_fb[idx] = shadow_fb[idx] & ~mask;
               end
            end
         end
         OP_CLEAR: begin
            foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
         end
         OP_NEXT: begin
            wrap = (int'(stream_pos) + 1 >= FRAME_LEN);
            bytes_due.push_back(make_byte(stream_byte_at(stream_pos),
                                          stream_pos == 11'd0 ||
                                          stream_pos == 11'(CMD_BYTES),
                                          stream_pos == 11'(CMD_BYTES - 1) || wrap,
                                          wrap, 1'b1));
            stream_pos = wrap ? 11'd0 : stream_pos + 11'd1;
         end
         default: begin
            // contrast command; refresh position stays where it is
            contrast = (level < 8'(DEF_BRIGHTNESS_STEPS)) ? 8'(level << 3) : BRIGHT_MAX;
            bytes_due.push_back(make_byte(CTRL_CMD, 1'b1, 1'b0, 1'b0, 1'b0));
            bytes_due.push_back(make_byte(CMD_CONTRAST, 1'b0, 1'b0, 1'b0, 1'b0));
            bytes_due.push_back(make_byte(contrast, 1'b0, 1'b1, 1'b0, 1'b1));
         end
      endcase
   endtask

   function automatic int field_mismatch(input string name, input int want_v,
                                         input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      bus_byte_t want;
      if (reset) begin
         foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
         stream_pos = 11'd0;
         bus_addr   = BUS_ADDRESS_RESET;
         bytes_due.delete();
      end else begin
         // compare before taking new requests: a byte never belongs to this edge's request
         if (rsp_strobe) begin
            if (bytes_due.size() == 0) begin
               $display("%0t: bus byte expected none, got 0x%0h", $time, rsp_out_byte);
               err_count++;
            end else begin
               want = bytes_due.pop_front();
               err_count += field_mismatch("out_byte", int'(want.data),
                                           int'(rsp_out_byte));
               err_count += field_mismatch("bus_address", int'(want.addr),
                                           int'(rsp_bus_address));
               err_count += field_mismatch("first_of_transfer", int'(want.first),
                                           int'(rsp_first_of_transfer));
               err_count += field_mismatch("last_of_transfer", int'(want.last),
                                           int'(rsp_last_of_transfer));
               err_count += field_mismatch("frame_done", int'(want.done),
                                           int'(rsp_frame_done));
               err_count += field_mismatch("last_in_run", int'(want.run_end),
                                           int'(rsp_last_in_run));
            end
         end
         if (csr_valid && csr_ready) bus_addr = csr_data;
         if (start && !busy) apply_request(req_op, req_pos_x, req_pos_y, req_lit, req_level);
      end
      errors  <= err_count;
      pending <= bytes_due.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the paged framebuffer with directed and random plot, clear, refresh
// and brightness requests under random gaps, changes the bus address between
// phases, and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
   import pmfb_pkg::*;

   localparam int PHASE_ITEMS   = 107;
   localparam int CLEAR_LIMIT   = 30;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 20;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic signed [15:0] req_pos_x;
   logic signed [15:0] req_pos_y;
   logic               req_lit;
   logic [7:0]         req_level;
   logic               rsp_strobe;
   logic [7:0]         rsp_out_byte;
   logic [6:0]         rsp_bus_address;
   logic               rsp_first_of_transfer;
   logic               rsp_last_of_transfer;
   logic               rsp_frame_done;
   logic               rsp_last_in_run;
   logic               csr_valid;
   logic               csr_ready;
   logic [6:0]         csr_data;
   int                 errors;
   int                 pending;

   int calm_left;     // requests left in the current stretch without gaps
   int clears_sent;

   paged_mono_framebuffer_flush dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_lit               (req_lit),
      .req_level             (req_level),
      .rsp_strobe            (rsp_strobe),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_bus_address       (rsp_bus_address),
      .rsp_first_of_transfer (rsp_first_of_transfer),
      .rsp_last_of_transfer  (rsp_last_of_transfer),
      .rsp_frame_done        (rsp_frame_done),
      .rsp_last_in_run       (rsp_last_in_run),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data)
   );

   pmfb_flush_checker flush_check (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_op                (req_op),
      .req_pos_x             (req_pos_x),
      .req_pos_y             (req_pos_y),
      .req_lit               (req_lit),
      .req_level             (req_level),
      .rsp_strobe            (rsp_strobe),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_bus_address       (rsp_bus_address),
      .rsp_first_of_transfer (rsp_first_of_transfer),
      .rsp_last_of_transfer  (rsp_last_of_transfer),
      .rsp_frame_done        (rsp_frame_done),
      .rsp_last_in_run       (rsp_last_in_run),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_data              (csr_data),
      .errors                (errors),
      .pending               (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int next_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   task automatic send_request(input logic [1:0] op, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic lit,
                               input logic [7:0] level);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         @(negedge clock) start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start     <= 1'b1;
      req_op    <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_lit   <= lit;
      req_level <= level;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_random();
      int                 pick;
      logic [1:0]         op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [7:0]         level;
      pick  = $urandom_range(0, 99);
      x     = 16'($urandom);
      y     = 16'($urandom);
      level = 8'($urandom);
      if (pick < 55) begin
         op = OP_NEXT;
      end else if (pick < 85) begin
         op = OP_PLOT;
         if ($urandom_range(0, 6) != 0) begin
            x = 16'($urandom_range(0, DEF_PANEL_WIDTH - 1));
            y = 16'($urandom_range(0, DEF_PANEL_HEIGHT - 1));
         end else if ($urandom_range(0, 1) == 0) begin
            // just past an edge
            x = 16'($urandom_range(0, 1) ? -1 : DEF_PANEL_WIDTH);
            y = 16'($urandom_range(0, 1) ? -1 : DEF_PANEL_HEIGHT);
         end
      end else if (pick < 98 || clears_sent >= CLEAR_LIMIT) begin
         op = OP_BRIGHT;
         if ($urandom_range(0, 1) == 0) level = 8'($urandom_range(0, 40));
      end else begin
         op = OP_CLEAR;
         clears_sent++;
      end
      send_request(op, x, y, $urandom_range(0, 9) < 6, level);
   endtask

   task automatic hold_until_drained();
      @(negedge clock) start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_bus_address(input logic [6:0] value);
      // plot and clear leave nothing to wait on: give the queue time to empty
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (busy) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_data  <= 7'($urandom);
   endtask

   initial begin
      logic [6:0] addr_plan [4];
      int         phase_items;
      addr_plan   = '{7'd0, 7'd127, 7'd0, BUS_ADDRESS_RESET};
      addr_plan[2] = 7'($urandom_range(1, 126));
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = OP_PLOT;
      req_pos_x   = '0;
      req_pos_y   = '0;
      req_lit     = 1'b0;
      req_level   = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      calm_left   = 0;
      clears_sent = 0;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: clear mid-refresh, edges and corners, off-panel plots,
      // brightness limits, brightness mid-refresh
      send_request(OP_NEXT, 0, 0, 1'b0, 8'd0);
      send_request(OP_NEXT, -1, -1, 1'b1, 8'hFF);
      send_request(OP_NEXT, 0, 0, 1'b0, 8'd0);
      send_request(OP_CLEAR, -1, -1, 1'b1, 8'hFF);
      send_request(OP_PLOT, 0, 0, 1'b1, 8'd0);
      send_request(OP_PLOT, 16'(DEF_PANEL_WIDTH - 1), 16'(DEF_PANEL_HEIGHT - 1), 1'b1, 8'd0);
      send_request(OP_PLOT, 16'(DEF_PANEL_WIDTH - 1), 0, 1'b1, 8'd0);
      send_request(OP_PLOT, 0, 16'(DEF_PANEL_HEIGHT - 1), 1'b1, 8'd0);
      send_request(OP_PLOT, 5, 9, 1'b1, 8'd0);
      send_request(OP_PLOT, 5, 10, 1'b1, 8'd0);
      send_request(OP_PLOT, 5, 9, 1'b0, 8'd0);
      send_request(OP_PLOT, 16'(DEF_PANEL_WIDTH), 0, 1'b1, 8'd0);
      send_request(OP_PLOT, 0, 16'(DEF_PANEL_HEIGHT), 1'b1, 8'd0);
      send_request(OP_PLOT, -1, 5, 1'b1, 8'd0);
      send_request(OP_PLOT, 3, -32768, 1'b1, 8'd0);
      send_request(OP_PLOT, 32767, 32767, 1'b1, 8'd0);
      send_request(OP_BRIGHT, 0, 0, 1'b0, 8'd0);
      send_request(OP_BRIGHT, 0, 0, 1'b0, 8'(DEF_BRIGHTNESS_STEPS - 1));
      send_request(OP_BRIGHT, 0, 0, 1'b0, 8'(DEF_BRIGHTNESS_STEPS));
      send_request(OP_BRIGHT, 0, 0, 1'b0, 8'hFF);
      send_request(OP_NEXT, 0, 0, 1'b0, 8'd0);
      send_request(OP_BRIGHT, 0, 0, 1'b0, 8'd17);
      send_request(OP_NEXT, 0, 0, 1'b0, 8'd0);
      send_request(OP_NEXT, 0, 0, 1'b0, 8'd0);

      // random phases, one bus address each
      for (int ph = 0; ph < 4; ph++) begin
         write_bus_address(addr_plan[ph]);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 59) == 0) hold_until_drained();
            send_random();
            phase_items++;
         end
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
